// ===== rtl/c8x_pkg.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 executor package
// Shared types, commands and state codes for the CHIP-8 instruction executor.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = 12;
  localparam int SCR_W       = 64;
  localparam int SCR_H       = 32;
  localparam int SCR_HW      = 5;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = 4;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 88;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRMEM = 2'd1;
  localparam logic [1:0] CMD_RDROW = 2'd2;

  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_DELAY = 2'd1;
  localparam logic [1:0] TMR_SOUND = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_SPR_RD,
    ST_SPR_WAIT,
    ST_SPR_ROW,
    ST_BCD,
    ST_STORE,
    ST_LOAD_RD,
    ST_LOAD_WAIT,
    ST_LOAD_WR,
    ST_ROW_RD,
    ST_DONE
  } c8x_state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;     // latch input beat
    logic do_single;   // execute a simple instruction
    logic clr_init;    // reset counter to zero
    logic clr_row;     // clear screen row at counter
    logic spr_rd;      // issue memory read for sprite row at counter
    logic spr_row;     // xor sprite row into screen at counter
    logic bcd_wr;      // write bcd digit at counter
    logic st_wr;       // write register counter to memory
    logic ld_rd;       // issue memory read for register counter
    logic ld_wr;       // write loaded byte into register counter
    logic cnt_inc;     // advance counter
    logic row_rd;      // capture screen row
    logic out_load;    // load output register
  } c8x_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] op_hi;
    logic [7:0] kk;
    logic       is_cls;    // opcode is exactly the screen clear
    logic       cnt_last;
  } c8x_stat_t;

endpackage

// ===== rtl/c8x_ctrl.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 executor controller
// Sequences the multi-cycle operations and the stream handshake.
// ----------------------------------------------------------------------------
module c8x_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  c8x_pkg::c8x_stat_t stat,
  output c8x_pkg::c8x_cmd_t  cmd
);
  import c8x_pkg::*;

  c8x_state_t state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       done;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        state_nxt = ST_DONE;
        if (stat.cmd == CMD_RDROW) begin
          state_nxt = ST_ROW_RD;
        end else if (stat.cmd == CMD_EXEC) begin
          if (stat.is_cls) state_nxt = ST_CLEAR;
          else if (stat.op_hi == 4'hD) state_nxt = ST_SPR_RD;
          else if (stat.op_hi == 4'hF && stat.kk == 8'h33) state_nxt = ST_BCD;
          else if (stat.op_hi == 4'hF && stat.kk == 8'h55) state_nxt = ST_STORE;
          else if (stat.op_hi == 4'hF && stat.kk == 8'h65) state_nxt = ST_LOAD_RD;
        end
      end
      ST_CLEAR:     if (stat.cnt_last) state_nxt = ST_DONE;
      ST_SPR_RD:    state_nxt = stat.cnt_last ? ST_DONE : ST_SPR_WAIT;
      ST_SPR_WAIT:  state_nxt = ST_SPR_ROW;
      ST_SPR_ROW:   state_nxt = ST_SPR_RD;
      ST_BCD:       if (stat.cnt_last) state_nxt = ST_DONE;
      ST_STORE:     if (stat.cnt_last) state_nxt = ST_DONE;
      ST_LOAD_RD:   state_nxt = stat.cnt_last ? ST_DONE : ST_LOAD_WAIT;
      ST_LOAD_WAIT: state_nxt = ST_LOAD_WR;
      ST_LOAD_WR:   state_nxt = ST_LOAD_RD;
      ST_ROW_RD:    state_nxt = ST_DONE;
      ST_DONE:      if (!ovalid_r || out_tready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  assign done = (state_r == ST_DONE) && (!ovalid_r || out_tready);

  always_comb begin
    cmd = '0;
    in_tready = (state_r == ST_IDLE);
    cmd.capture = (state_r == ST_IDLE) && in_tvalid;
    unique case (state_r)
      ST_DECODE: begin
        cmd.clr_init = 1'b1;
        cmd.do_single = (stat.cmd != CMD_RDROW);
      end
      ST_CLEAR:   begin cmd.clr_row = 1'b1; cmd.cnt_inc = 1'b1; end
      ST_SPR_RD:  cmd.spr_rd = !stat.cnt_last;
      ST_SPR_ROW: begin cmd.spr_row = 1'b1; cmd.cnt_inc = 1'b1; end
      ST_BCD:     begin cmd.bcd_wr = 1'b1; cmd.cnt_inc = 1'b1; end
      ST_STORE:   begin cmd.st_wr = 1'b1; cmd.cnt_inc = 1'b1; end
      ST_LOAD_RD: cmd.ld_rd = !stat.cnt_last;
      ST_LOAD_WR: begin cmd.ld_wr = 1'b1; cmd.cnt_inc = 1'b1; end
      ST_ROW_RD:  cmd.row_rd = 1'b1;
      ST_DONE:    cmd.out_load = done;
      default:    ;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    if (done) ovalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_DECODE) else $error("no decode");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid) else $error("result lost");

endmodule

// ===== rtl/c8x_dp.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 executor datapath
// Registers, stack, main memory, screen and the result register.
// ----------------------------------------------------------------------------
module c8x_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [c8x_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [1:0]                        in_tuser,
  input  c8x_pkg::c8x_cmd_t                 cmd,
  output c8x_pkg::c8x_stat_t                stat,
  output logic [c8x_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import c8x_pkg::*;

  logic [1:0]  cmd_r;
  logic [15:0] op_r;
  logic [7:0]  rnd_r, dly_r, dat_r;
  logic [15:0] keys_r;
  logic [11:0] addr_r;

  logic [7:0]  v_r [16];
  logic [15:0] i_r;
  logic [11:0] pc_r;
  logic [SP_W-1:0] sp_r;
  logic [11:0] stk [STACK_DEPTH];
  logic [7:0]  mem [MEM_BYTES];
  logic [SCR_W-1:0] scr_r [SCR_H];

  logic [4:0]  cnt_r;
  logic [7:0]  mrd_r;
  logic [SCR_W-1:0] row_r;
  logic        hit_r;
  logic        wait_r, bad_r;
  logic [1:0]  tw_r;
  logic [7:0]  tv_r;
  logic [OUT_DATA_W-1:0] out_r;
  logic [11:0] stk_rd;

  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn, pc2, pc4;
  logic [4:0]  cnt_end;
  logic [3:0]  cnt4;
  logic [SCR_HW:0] srow;
  logic [5:0]  x0;
  logic [SCR_HW-1:0] y0;
  logic [SCR_W+7:0] spr_wide;
  logic [SCR_W-1:0] spr_mask;
  logic [MEM_AW-1:0] maddr;
  logic [7:0]  hund, tens, ones;
  logic [6:0]  rem100;
  logic [14:0] tens_prod;
  logic [8:0]  sum9;
  logic        down;
  logic [3:0]  lowkey;

  assign x   = op_r[11:8];
  assign y   = op_r[7:4];
  assign n   = op_r[3:0];
  assign kk  = op_r[7:0];
  assign nnn = op_r[11:0];
  assign vx  = v_r[x];
  assign vy  = v_r[y];
  assign pc2 = pc_r + 12'd2;
  assign pc4 = pc_r + 12'd4;
  assign cnt4 = cnt_r[3:0];
  assign x0 = vx[5:0];
  assign y0 = vy[SCR_HW-1:0];
  assign srow = {1'b0, y0} + {2'b0, cnt4};
  assign maddr = i_r[MEM_AW-1:0] + {8'd0, cnt4};
  assign spr_wide = {mrd_r, {SCR_W{1'b0}}} >> x0;
  assign spr_mask = spr_wide[SCR_W+7:8];
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign down = (vx < 8'd16) && keys_r[vx[3:0]];

  // Hundreds by compare and subtract, then tens as n * 205 >> 11, which
  // equals n / 10 for every n below 100.
  always_comb begin
    if (vx >= 8'd200) begin
      hund = 8'd2;
      rem100 = 7'(vx - 8'd200);
    end else if (vx >= 8'd100) begin
      hund = 8'd1;
      rem100 = 7'(vx - 8'd100);
    end else begin
      hund = 8'd0;
      rem100 = vx[6:0];
    end
  end
  assign tens_prod = {8'd0, rem100} * 15'd205;
  assign tens = {4'd0, tens_prod[14:11]};
  assign ones = {1'b0, rem100} - {tens[4:0], 3'b000} - {tens[6:0], 1'b0};

  always_comb begin
    lowkey = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) lowkey = 4'(k);
    end
  end

  always_comb begin
    cnt_end = 5'd0;
    if (cmd_r == CMD_EXEC && op_r[15:12] == 4'h0) cnt_end = 5'(SCR_H - 1);
    else if (op_r[15:12] == 4'hD) cnt_end = {1'b0, n};
    else if (kk == 8'h33) cnt_end = 5'd2;
    else if (kk == 8'h55) cnt_end = {1'b0, x};
    else cnt_end = {1'b0, x} + 5'd1;
  end

  assign stat.cmd   = cmd_r;
  assign stat.op_hi = op_r[15:12];
  assign stat.kk    = kk;
  assign stat.is_cls = (op_r == 16'h00E0);
  assign stat.cnt_last = (op_r[15:12] == 4'hD) ?
    ((cnt_r == cnt_end) || srow[SCR_HW]) : (cnt_r == cnt_end);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_tuser;
      op_r   <= in_tdata[15:0];
      rnd_r  <= in_tdata[23:16];
      keys_r <= in_tdata[39:24];
      dly_r  <= in_tdata[47:40];
      addr_r <= in_tdata[59:48];
      dat_r  <= in_tdata[67:60];
    end
    if (cmd.clr_init) cnt_r <= 5'd0;
    else if (cmd.cnt_inc) cnt_r <= cnt_r + 5'd1;
  end

  // Memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.spr_rd || cmd.ld_rd) mrd_r <= mem[maddr];
    if (cmd.do_single && cmd_r == CMD_WRMEM) mem[addr_r] <= dat_r;
    else if (cmd.bcd_wr)
      mem[maddr] <= (cnt_r == 5'd0) ? hund : (cnt_r == 5'd1) ? tens : ones;
    else if (cmd.st_wr) mem[maddr] <= v_r[cnt4];
  end

  assign stk_rd = stk[sp_r - SP_W'(1)];
  always_ff @(posedge clk) begin
    if (cmd.do_single && cmd_r == CMD_EXEC && op_r[15:12] == 4'h2)
      stk[sp_r] <= pc2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < SCR_H; r++) scr_r[r] <= '0;
      for (int r = 0; r < 16; r++) v_r[r] <= 8'd0;
      i_r  <= 16'd0;
      pc_r <= 12'd512;
      sp_r <= '0;
    end else begin
      if (cmd.clr_row) scr_r[cnt_r] <= '0;
      if (cmd.spr_row) scr_r[srow[SCR_HW-1:0]] <= scr_r[srow[SCR_HW-1:0]] ^ spr_mask;
      if (cmd.ld_wr) v_r[cnt4] <= mrd_r;
      if (cmd.out_load && cmd_r == CMD_EXEC && op_r[15:12] == 4'hD)
        v_r[15] <= {7'd0, hit_r};
      if (cmd.do_single && cmd_r == CMD_EXEC) begin
        pc_r <= pc2;
        unique case (op_r[15:12])
          4'h0: if (op_r == 16'h00EE) begin
            sp_r <= sp_r - SP_W'(1);
            pc_r <= stk_rd;
          end
          4'h1: pc_r <= nnn;
          4'h2: begin sp_r <= sp_r + SP_W'(1); pc_r <= nnn; end
          4'h3: if (vx == kk) pc_r <= pc4;
          4'h4: if (vx != kk) pc_r <= pc4;
          4'h5: if (vx == vy) pc_r <= pc4;
          4'h6: v_r[x] <= kk;
          4'h7: v_r[x] <= vx + kk;
          4'h8: begin
            unique case (n)
              4'h0: v_r[x] <= vy;
              4'h1: v_r[x] <= vx | vy;
              4'h2: v_r[x] <= vx & vy;
              4'h3: v_r[x] <= vx ^ vy;
              4'h4: begin v_r[x] <= sum9[7:0]; v_r[15] <= {7'd0, sum9[8]}; end
              4'h5: begin v_r[x] <= vx - vy; v_r[15] <= {7'd0, vx > vy}; end
              4'h6: begin v_r[x] <= vx >> 1; v_r[15] <= {7'd0, vx[0]}; end
              4'h7: begin v_r[x] <= vy - vx; v_r[15] <= {7'd0, vy > vx}; end
              4'hE: begin v_r[x] <= {vx[6:0], 1'b0}; v_r[15] <= {7'd0, vx[7]}; end
              default: ;
            endcase
          end
          4'h9: if (vx != vy) pc_r <= pc4;
          4'hA: i_r <= {4'd0, nnn};
          4'hB: pc_r <= nnn + {4'd0, v_r[0]};
          4'hC: v_r[x] <= rnd_r & kk;
          4'hE: begin
            if ((kk == 8'h9E && down) || (kk == 8'hA1 && !down)) pc_r <= pc4;
          end
          4'hF: begin
            unique case (kk)
              8'h07: v_r[x] <= dly_r;
              8'h0A: begin
                if (keys_r != 16'd0) v_r[x] <= {4'd0, lowkey};
                else pc_r <= pc_r;
              end
              8'h1E: i_r <= i_r + {8'd0, vx};
              8'h29: i_r <= {8'd0, vx} * 16'd5;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_init) hit_r <= 1'b0;
    else if (cmd.spr_row && ((scr_r[srow[SCR_HW-1:0]] & spr_mask) != '0)) hit_r <= 1'b1;
    if (cmd.row_rd)
      row_r <= (addr_r < 12'(SCR_H)) ? scr_r[addr_r[SCR_HW-1:0]] : '0;
    else if (cmd.capture) row_r <= '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_single) begin
      wait_r <= 1'b0; bad_r <= 1'b0; tw_r <= TMR_NONE; tv_r <= 8'd0;
      if (cmd_r == CMD_EXEC) begin
        unique case (op_r[15:12])
          4'h0: bad_r <= (op_r != 16'h00E0) && (op_r != 16'h00EE);
          4'h8: bad_r <= (n > 4'h7) && (n != 4'hE);
          4'hE: bad_r <= (kk != 8'h9E) && (kk != 8'hA1);
          4'hF: begin
            bad_r <= !(kk == 8'h07 || kk == 8'h0A || kk == 8'h15 || kk == 8'h18 ||
                       kk == 8'h1E || kk == 8'h29 || kk == 8'h33 || kk == 8'h55 ||
                       kk == 8'h65);
            wait_r <= (kk == 8'h0A) && (keys_r == 16'd0);
            if (kk == 8'h15) begin tw_r <= TMR_DELAY; tv_r <= vx; end
            if (kk == 8'h18) begin tw_r <= TMR_SOUND; tv_r <= vx; end
          end
          default: ;
        endcase
      end
    end else if (cmd.capture) begin
      wait_r <= 1'b0; bad_r <= 1'b0; tw_r <= TMR_NONE; tv_r <= 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_r <= {bad_r, row_r, tv_r, tw_r, wait_r, pc_r};
  end
  assign out_tdata = out_r;

endmodule

// ===== rtl/chip8_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 instruction executor
// Top level: controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
// Each input beat is one command (execute, write memory byte, read screen row)
// and gives exactly one result beat. Simple instructions, memory writes and
// row reads take no walk; screen clear walks all rows, a sprite draw reads,
// waits for and updates each sprite row, BCD and block store write one byte
// per cycle, and block load reads, waits for and writes each register, all set
// by the registered read of the 4 KiB memory and the row-wide screen update.
// A held-back result lets the next input beat in but stalls its result.
module chip8_instruction_executor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // instruction, random_byte, keys_down, delay_now, address, data, zero pad
  input  logic [c8x_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // program_counter, waiting_key, timer_write, timer_value, screen_row,
  // bad_opcode
  output logic [c8x_pkg::OUT_DATA_W-1:0] out_tdata
);
  import c8x_pkg::*;

  c8x_cmd_t  cmd;
  c8x_stat_t stat;

  c8x_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .stat, .cmd
  );

  c8x_dp u_dp (
    .clk, .rst_n, .in_tdata, .in_tuser, .cmd, .stat, .out_tdata
  );

endmodule
